// ===== design/nswl_pkg.sv =====
// nswl_pkg: shared types and constants of the nearest swing level finder
// no dependencies; imported by the divider and the top level

package nswl_pkg;

  // fixed field widths
  localparam int DIST_W    = 32;
  localparam int LIMIT_W   = 16;
  localparam int MINH_W    = 8;
  localparam int FRAC_BITS = 16;
  localparam int PCT_BITS  = 7;   // width of the scale factor 100

  // apb register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_LOOK_LIMIT  = 1'b0;
  localparam logic REG_MIN_HISTORY = 1'b1;

  localparam logic [LIMIT_W-1:0] LOOK_LIMIT_RST  = 16'd60;
  localparam logic [MINH_W-1:0]  MIN_HISTORY_RST = 8'd5;

  // distance saturation
  localparam logic [DIST_W-1:0] SAT_MAG    = 32'h8000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX   = 32'h7fff_ffff;
  localparam logic [DIST_W:0]   SAT_THRESH = 33'h0_8000_0000;

  // result slots: support nearest, support second, resistance nearest, resistance second
  localparam logic [1:0] LAST_LEVEL = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SCALE,
    DIV_RUN
  } div_state_e;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] mag;
  } div_out_t;

endpackage

// ===== design/nswl_if.sv =====
// nswl_in_if and nswl_out_if: valid/ready channels of the swing level finder
// no dependencies

interface nswl_in_if #(
  parameter int PRICE_BITS = 48,
  parameter int TIME_BITS  = 48
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] candle_high;
  logic [PRICE_BITS-1:0] candle_low;
  logic [TIME_BITS-1:0]  candle_time;
  logic                  candle_valid;
  logic [PRICE_BITS-1:0] market_price;
  logic                  scan_end;

  modport source (
    output valid, candle_high, candle_low, candle_time, candle_valid,
           market_price, scan_end,
    input  ready
  );
  modport sink (
    input  valid, candle_high, candle_low, candle_time, candle_valid,
           market_price, scan_end,
    output ready
  );
endinterface

interface nswl_out_if #(
  parameter int PRICE_BITS = 48,
  parameter int TIME_BITS  = 48,
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  level_kind;
  logic                  level_rank;
  logic                  level_valid;
  logic [PRICE_BITS-1:0] swing_price;
  logic [TIME_BITS-1:0]  level_time;
  logic [INDEX_BITS-1:0] candles_back;
  logic signed [31:0]    offset_pct;
  logic                  snapshot_valid;
  logic                  last_of_run;

  modport source (
    output valid, level_kind, level_rank, level_valid, swing_price, level_time,
           candles_back, offset_pct, snapshot_valid, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, level_kind, level_rank, level_valid, swing_price, level_time,
           candles_back, offset_pct, snapshot_valid, last_of_run,
    output ready
  );
endinterface

// ===== design/nswl_div.sv =====
// nswl_div: bit-serial restoring divider for the percent distance
// computes min(floor(diff*100*2^16 / den), 2^31); depends on nswl_pkg

module nswl_div import nswl_pkg::*; #(
  parameter int PRICE_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PRICE_BITS-1:0] diff_i,
  input  logic [PRICE_BITS-1:0] den_i,
  output div_out_t              div_o
);

  localparam int MUL_W = PRICE_BITS + PCT_BITS;
  localparam int NUM_W = MUL_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  div_state_e state_q, state_d;
  logic done_q, done_d;

  logic [PRICE_BITS-1:0] diff_q, diff_d;
  logic [PRICE_BITS-1:0] den_q, den_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [PRICE_BITS-1:0] rem_q, rem_d;
  logic [DIST_W:0]       quo_q, quo_d;
  logic                  sat_q, sat_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [MUL_W-1:0]      scaled;
  logic [PRICE_BITS:0]   shifted;
  logic [PRICE_BITS:0]   den_ext;
  logic                  fits;
  logic [PRICE_BITS:0]   sub;
  logic [DIST_W:0]       quo_next;

  // diff * 100 as shift-add: 64 + 32 + 4
  assign scaled = (MUL_W'(diff_q) << 6) + (MUL_W'(diff_q) << 5) + (MUL_W'(diff_q) << 2);

  assign shifted  = {rem_q, num_q[NUM_W-1]};
  assign den_ext  = {1'b0, den_q};
  assign fits     = shifted >= den_ext;
  assign sub      = shifted - den_ext;
  assign quo_next = {quo_q[DIST_W-1:0], fits};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    diff_d  = diff_q;
    den_d   = den_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    sat_d   = sat_q;
    cnt_d   = cnt_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          diff_d  = diff_i;
          den_d   = den_i;
          state_d = DIV_SCALE;
        end
      end
      DIV_SCALE: begin
        num_d   = {scaled, {FRAC_BITS{1'b0}}};
        rem_d   = '0;
        quo_d   = '0;
        sat_d   = 1'b0;
        cnt_d   = '0;
        state_d = DIV_RUN;
      end
      DIV_RUN: begin
        num_d = num_q << 1;
        rem_d = fits ? sub[PRICE_BITS-1:0] : shifted[PRICE_BITS-1:0];
        // quotient freezes once it passes the cap
        if (!sat_q) begin
          quo_d = quo_next;
          if (quo_next > SAT_THRESH) begin
            sat_d = 1'b1;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    den_q  <= den_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    sat_q  <= sat_d;
    cnt_q  <= cnt_d;
  end

  assign div_o.done = done_q;
  assign div_o.mag  = sat_q ? SAT_MAG : quo_q[DIST_W-1:0];

endmodule

// ===== design/nearest_swing_level_finder_unit.sv =====
// nearest_swing_level_finder_unit: top level of the swing level finder
// depends on nswl_pkg, nswl_in_if, nswl_out_if and nswl_div

// usage
// - cand_i carries candles newest first; the item with scan_end set closes the scan
// - the market price is taken from the first item of every scan
// - a candle that does not end a scan is accepted while ready stays high
// - the scan_end item starts the result sequence: four items on lvl_o in the
//   order support nearest, support second, resistance nearest, resistance second
// - an invalid level passes through the load and emit states; a valid one also
//   waits in the div state for the bit-serial divider that forms offset_pct (one quotient
//   bit per cycle over PRICE_BITS + 23 numerator bits)
// - cand_i ready is low for the whole result sequence
// - a stalled lvl_o holds the current item; the next one waits in the sequencer,
//   and after the last item candles are taken again while it still waits
// - apb registers: look-back limit at 0x0, min_history at 0x4; write only while idle
// - reset clears the scan, the found flags and the output valid, and loads the
//   register defaults (look-back limit 60, min_history 5)

module nearest_swing_level_finder_unit import nswl_pkg::*; #(
  parameter int PRICE_BITS = 48,
  parameter int TIME_BITS  = 48,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  nswl_in_if.sink               cand_i,
  nswl_out_if.source            lvl_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // compare widths for the scan limit and the history count
  localparam int LIM_W = (INDEX_BITS > LIMIT_W) ? INDEX_BITS : LIMIT_W;
  localparam int CNT_W = (INDEX_BITS + 1 > MINH_W) ? INDEX_BITS + 1 : MINH_W;

  // configuration registers
  logic [LIMIT_W-1:0] look_limit_q;
  logic [MINH_W-1:0]  min_hist_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_limit_q <= LOOK_LIMIT_RST;
      min_hist_q   <= MIN_HISTORY_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LOOK_LIMIT:  look_limit_q <= pwdata[LIMIT_W-1:0];
        REG_MIN_HISTORY: min_hist_q   <= pwdata[MINH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOOK_LIMIT:  prdata = APB_DATA_W'(look_limit_q);
      REG_MIN_HISTORY: prdata = APB_DATA_W'(min_hist_q);
      default:         prdata = '0;
    endcase
  end

  // sequencer and scan state
  seq_state_e state_q, state_d;
  logic [1:0] slot_q, slot_d;       // result slot: bit 1 kind, bit 0 rank
  logic       good_q, good_d;       // enough history and nonzero price
  logic       neg_q, neg_d;         // level below price

  logic [INDEX_BITS-1:0] pos_q, pos_d;
  logic [PRICE_BITS-1:0] latch_q, latch_d;

  // two-candle window, index 0 newer
  logic [PRICE_BITS-1:0] win_high_q [2];
  logic [PRICE_BITS-1:0] win_high_d [2];
  logic [PRICE_BITS-1:0] win_low_q  [2];
  logic [PRICE_BITS-1:0] win_low_d  [2];
  logic [TIME_BITS-1:0]  win_time_q [2];
  logic [TIME_BITS-1:0]  win_time_d [2];
  logic [1:0]            win_ok_q, win_ok_d;

  // nearest-two lists: 0/1 support, 2/3 resistance
  logic [PRICE_BITS-1:0] near_price_q [4];
  logic [PRICE_BITS-1:0] near_price_d [4];
  logic [TIME_BITS-1:0]  near_time_q  [4];
  logic [TIME_BITS-1:0]  near_time_d  [4];
  logic [INDEX_BITS-1:0] near_back_q  [4];
  logic [INDEX_BITS-1:0] near_back_d  [4];
  logic [3:0]            found_q, found_d;

  // output register
  logic                  out_vld_q, out_vld_d;
  logic                  out_load;
  logic                  o_kind_q, o_rank_q, o_valid_q, o_snap_q, o_last_q;
  logic [PRICE_BITS-1:0] o_price_q;
  logic [TIME_BITS-1:0]  o_time_q;
  logic [INDEX_BITS-1:0] o_back_q;
  logic [DIST_W-1:0]     o_dist_q, gap_val;

  // candle path
  logic                  accept;
  logic [PRICE_BITS-1:0] price_now;
  logic                  in_window;
  logic                  res_hit, sup_hit;
  logic [INDEX_BITS-1:0] swing_back;
  logic                  good_new;
  logic                  scan_clear;

  // result path
  logic [PRICE_BITS-1:0] lvl_price;
  logic                  lvl_below;
  logic [PRICE_BITS-1:0] lvl_diff;
  logic                  lvl_ok;
  logic                  div_start;
  div_out_t              div_res;

  assign cand_i.ready = (state_q == ST_IDLE);
  assign accept       = cand_i.valid && (state_q == ST_IDLE);

  // price of this scan, taken from the first candle
  assign price_now = (pos_q == '0) ? cand_i.market_price : latch_q;

  assign in_window = (pos_q >= INDEX_BITS'(2))
                  && (LIM_W'(pos_q) < LIM_W'(look_limit_q))
                  && cand_i.candle_valid && win_ok_q[0] && win_ok_q[1];

  // strict swings of the middle candle
  assign res_hit = in_window && (win_high_q[0] > cand_i.candle_high)
                && (win_high_q[0] > win_high_q[1]) && (win_high_q[0] > price_now);
  assign sup_hit = in_window && (win_low_q[0] < cand_i.candle_low)
                && (win_low_q[0] < win_low_q[1]) && (win_low_q[0] < price_now);

  assign swing_back = pos_q - INDEX_BITS'(1);
  assign good_new   = (CNT_W'(pos_q) + CNT_W'(1) >= CNT_W'(min_hist_q))
                   && (price_now != '0);

  // scan state: window, position, price latch and nearest lists
  always_comb begin
    logic                  hit;
    logic [PRICE_BITS-1:0] cand;
    logic                  nearer_a, nearer_b;
    logic [1:0]            a, b;
    hit          = 1'b0;
    cand         = '0;
    nearer_a     = 1'b0;
    nearer_b     = 1'b0;
    a            = '0;
    b            = '0;
    pos_d        = pos_q;
    latch_d      = latch_q;
    win_high_d   = win_high_q;
    win_low_d    = win_low_q;
    win_time_d   = win_time_q;
    win_ok_d     = win_ok_q;
    near_price_d = near_price_q;
    near_time_d  = near_time_q;
    near_back_d  = near_back_q;
    found_d      = found_q;
    if (accept) begin
      if (pos_q == '0) begin
        latch_d = cand_i.market_price;
      end
      // side 0 support (higher is nearer), side 1 resistance (lower is nearer)
      for (int s = 0; s < 2; s++) begin
        a        = 2'(2 * s);
        b        = 2'(2 * s + 1);
        hit      = (s == 1) ? res_hit : sup_hit;
        cand     = (s == 1) ? win_high_q[0] : win_low_q[0];
        nearer_a = (s == 1) ? (cand < near_price_q[a]) : (cand > near_price_q[a]);
        nearer_b = (s == 1) ? (cand < near_price_q[b]) : (cand > near_price_q[b]);
        if (hit) begin
          if (!found_q[a] || nearer_a) begin
            near_price_d[b] = near_price_q[a];
            near_time_d[b]  = near_time_q[a];
            near_back_d[b]  = near_back_q[a];
            found_d[b]      = found_q[a];
            near_price_d[a] = cand;
            near_time_d[a]  = win_time_q[0];
            near_back_d[a]  = swing_back;
            found_d[a]      = 1'b1;
          end else if (!found_q[b] || nearer_b) begin
            near_price_d[b] = cand;
            near_time_d[b]  = win_time_q[0];
            near_back_d[b]  = swing_back;
            found_d[b]      = 1'b1;
          end
        end
      end
      win_high_d[1] = win_high_q[0];
      win_low_d[1]  = win_low_q[0];
      win_time_d[1] = win_time_q[0];
      win_ok_d[1]   = win_ok_q[0];
      win_high_d[0] = cand_i.candle_high;
      win_low_d[0]  = cand_i.candle_low;
      win_time_d[0] = cand_i.candle_time;
      win_ok_d[0]   = cand_i.candle_valid;
      if (pos_q != '1) begin
        pos_d = pos_q + INDEX_BITS'(1);
      end
    end
    // end of the result sequence starts a fresh scan
    if (scan_clear) begin
      pos_d    = '0;
      win_ok_d = '0;
      found_d  = '0;
    end
  end

  // level of the current slot against the latched price
  assign lvl_price = near_price_q[slot_q];
  assign lvl_below = lvl_price < latch_q;
  assign lvl_diff  = lvl_below ? (latch_q - lvl_price) : (lvl_price - latch_q);
  assign lvl_ok    = good_q && found_q[slot_q];

  nswl_div #(
    .PRICE_BITS (PRICE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (lvl_diff),
    .den_i   (latch_q),
    .div_o   (div_res)
  );

  // signed distance with saturation
  always_comb begin
    if (!lvl_ok) begin
      gap_val = '0;
    end else if (neg_q) begin
      gap_val = (div_res.mag >= SAT_MAG) ? SAT_MAG : (DIST_W'(0) - div_res.mag);
    end else begin
      gap_val = (div_res.mag > DIST_MAX) ? DIST_MAX : div_res.mag;
    end
  end

  // result sequencer
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    good_d     = good_q;
    neg_d      = neg_q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    scan_clear = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && cand_i.scan_end) begin
          good_d  = good_new;
          slot_d  = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (lvl_ok) begin
          div_start = 1'b1;
          neg_d     = lvl_below;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || lvl_o.ready) begin
          out_load = 1'b1;
          if (slot_q == LAST_LEVEL) begin
            scan_clear = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            slot_d  = slot_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && lvl_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      good_q    <= 1'b0;
      pos_q     <= '0;
      latch_q   <= '0;
      win_ok_q  <= '0;
      found_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      good_q    <= good_d;
      pos_q     <= pos_d;
      latch_q   <= latch_d;
      win_ok_q  <= win_ok_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    neg_q        <= neg_d;
    win_high_q   <= win_high_d;
    win_low_q    <= win_low_d;
    win_time_q   <= win_time_d;
    near_price_q <= near_price_d;
    near_time_q  <= near_time_d;
    near_back_q  <= near_back_d;
    if (out_load) begin
      o_kind_q  <= slot_q[1];
      o_rank_q  <= slot_q[0];
      o_valid_q <= lvl_ok;
      o_price_q <= lvl_ok ? lvl_price : '0;
      o_time_q  <= lvl_ok ? near_time_q[slot_q] : '0;
      o_back_q  <= lvl_ok ? near_back_q[slot_q] : '0;
      o_dist_q  <= gap_val;
      o_snap_q  <= good_q && (found_q[0] || found_q[2]);
      o_last_q  <= (slot_q == LAST_LEVEL);
    end
  end

  assign lvl_o.valid          = out_vld_q;
  assign lvl_o.level_kind     = o_kind_q;
  assign lvl_o.level_rank     = o_rank_q;
  assign lvl_o.level_valid    = o_valid_q;
  assign lvl_o.swing_price    = o_price_q;
  assign lvl_o.level_time     = o_time_q;
  assign lvl_o.candles_back   = o_back_q;
  assign lvl_o.offset_pct     = o_dist_q;
  assign lvl_o.snapshot_valid = o_snap_q;
  assign lvl_o.last_of_run    = o_last_q;

endmodule
